// File: rtl/core/bra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants for the bump allocator
// Operation and status codes, FSM states, controller/datapath links.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam int unsigned HEADER_BYTES_DEF  = 8;
    localparam int unsigned ALIGN_BITS        = 12;    // 0x1000 alignment
    localparam int unsigned ENTRY_W           = 65;    // {free, length, base}

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ALIGN = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SCAN_EXACT  = 2'd0,
        SCAN_SHRINK = 2'd1,
        SCAN_FREE   = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        RES_NONE      = 2'd0,
        RES_HALTED    = 2'd1,
        RES_NOT_FOUND = 2'd2
    } res_kind_t;

    typedef enum logic [2:0] {
        FSM_IDLE        = 3'd0,
        FSM_DISPATCH    = 3'd1,
        FSM_AFTER_EXACT = 3'd2,
        FSM_TAKE_HDR    = 3'd3,
        FSM_TAKE_SIZE   = 3'd4,
        FSM_SCAN        = 3'd5,
        FSM_RESP        = 3'd6
    } fsm_state_t;

    typedef struct packed {
        logic       take_in;
        logic       init_op;
        logic       align_op;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       scan_run;
        logic       hit_write;
        logic       take_hdr;
        logic       take_size;
        res_kind_t  res_kind;
        logic       out_load;
    } bra_cmd_t;

    typedef struct packed {
        logic       halted;
        op_t        op;
        logic       fsc_zero;
        logic       fsc_lt_n;
        logic       ready;
        logic       used_zero;
        logic       used_full;
        logic       hdr_fail;
        logic       scan_hit;
        logic       scan_miss;
        scan_mode_t mode;
        logic       out_busy;
    } bra_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/bump_allocator_with_reuse_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bump_allocator_with_reuse_table_unit: heap allocator with reuse table
// Bump allocation with a header table, exact-size and shrink reuse, free.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  s_axis    | in  | tvalid/tready    | tuser op, tdata {address, size_bytes}
//  m_axis    | out | tvalid/tready    | tuser status, tdata block_address
//  apb       | in  | psel/penable     | reg 0 heap_limit at byte address 0
//
//  One word at a time: init, align and halted skip the table; alloc and free
//  scan the entry RAM one entry per cycle through its single read port.
//  A finished word waits in the output register while the next is taken.
//  Reset clears pointer and used count, sets fsc full; table is not cleared.
// ----------------------------------------------------------------------------
module bump_allocator_with_reuse_table_unit #(
    parameter int unsigned TABLE_ENTRIES = bra_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned HEADER_BYTES  = bra_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] size_bytes, [63:32] address
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] block_address
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] ADDR_HEAP_LIMIT = 3'd0;

    logic [31:0]        heap_limit_reg;
    bra_pkg::bra_cmd_t  cmd;
    bra_pkg::bra_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HEAP_LIMIT) ? heap_limit_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= 32'hFFFF_FFFF;
        end
        else if (psel && penable && pwrite && paddr == ADDR_HEAP_LIMIT)
        begin
            heap_limit_reg <= pwdata;
        end
    end

    bra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bra_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_op             (s_axis_tuser),
        .in_size           (s_axis_tdata[31:0]),
        .in_addr           (s_axis_tdata[63:32]),
        .heap_limit        (heap_limit_reg),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_block_address (m_axis_tdata),
        .out_status        (m_axis_tuser)
    );

endmodule
`default_nettype wire

// File: rtl/core/bra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/bra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ctrl: request sequencer
// Walks one request through dispatch, table scans, bump steps and reply.
// ----------------------------------------------------------------------------
module bra_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bra_pkg::bra_stat_t stat,
    output bra_pkg::bra_cmd_t      cmd
);

    bra_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bra_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            bra_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = bra_pkg::FSM_DISPATCH;
                end
            end
            bra_pkg::FSM_DISPATCH:
            begin
                if (stat.halted)
                begin
                    cmd.res_kind = bra_pkg::RES_HALTED;
                    state_next   = bra_pkg::FSM_RESP;
                end
                else
                begin
                    case (stat.op)
                        bra_pkg::OP_INIT:
                        begin
                            cmd.init_op = 1'b1;
                            state_next  = bra_pkg::FSM_RESP;
                        end
                        bra_pkg::OP_ALIGN:
                        begin
                            cmd.align_op = 1'b1;
                            state_next   = bra_pkg::FSM_TAKE_SIZE;
                        end
                        bra_pkg::OP_FREE:
                        begin
                            if (stat.used_zero)
                            begin
                                cmd.res_kind = bra_pkg::RES_NOT_FOUND;
                                state_next   = bra_pkg::FSM_RESP;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                cmd.scan_mode  = bra_pkg::SCAN_FREE;
                                state_next     = bra_pkg::FSM_SCAN;
                            end
                        end
                        default:
                        begin
                            if (stat.fsc_zero || !stat.ready)
                            begin
                                state_next = bra_pkg::FSM_TAKE_SIZE;
                            end
                            else if (stat.fsc_lt_n && !stat.used_zero)
                            begin
                                cmd.scan_start = 1'b1;
                                cmd.scan_mode  = bra_pkg::SCAN_EXACT;
                                state_next     = bra_pkg::FSM_SCAN;
                            end
                            else
                            begin
                                state_next = bra_pkg::FSM_AFTER_EXACT;
                            end
                        end
                    endcase
                end
            end
            bra_pkg::FSM_AFTER_EXACT:
            begin
                if (stat.used_full)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = bra_pkg::SCAN_SHRINK;
                    state_next     = bra_pkg::FSM_SCAN;
                end
                else
                begin
                    state_next = bra_pkg::FSM_TAKE_HDR;
                end
            end
            bra_pkg::FSM_TAKE_HDR:
            begin
                cmd.take_hdr = 1'b1;
                state_next   = stat.hdr_fail ? bra_pkg::FSM_RESP : bra_pkg::FSM_TAKE_SIZE;
            end
            bra_pkg::FSM_TAKE_SIZE:
            begin
                cmd.take_size = 1'b1;
                state_next    = bra_pkg::FSM_RESP;
            end
            bra_pkg::FSM_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.hit_write = 1'b1;
                    state_next    = bra_pkg::FSM_RESP;
                end
                else if (stat.scan_miss)
                begin
                    case (stat.mode)
                        bra_pkg::SCAN_EXACT:  state_next = bra_pkg::FSM_AFTER_EXACT;
                        bra_pkg::SCAN_SHRINK: state_next = bra_pkg::FSM_TAKE_SIZE;
                        default:
                        begin
                            cmd.res_kind = bra_pkg::RES_NOT_FOUND;
                            state_next   = bra_pkg::FSM_RESP;
                        end
                    endcase
                end
            end
            bra_pkg::FSM_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bra_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = bra_pkg::FSM_IDLE;
            end
        endcase
    end

    // a scan step never hits and misses at once
    a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.scan_hit && stat.scan_miss))
        else $error("scan hit and miss together");

    // the reply stage always follows a bump of the block itself
    a_size_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bra_pkg::FSM_TAKE_SIZE |=> state_reg == bra_pkg::FSM_RESP)
        else $error("bump step not followed by reply");

    a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == bra_pkg::FSM_IDLE)
        else $error("reply load without return to idle");

endmodule
`default_nettype wire

// File: rtl/core/bra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bra_dp: allocator datapath
// Bump pointer, counters, entry table RAM, scan pipeline and reply register.
// ----------------------------------------------------------------------------
module bra_dp #(
    parameter int unsigned TABLE_ENTRIES = bra_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned HEADER_BYTES  = bra_pkg::HEADER_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bra_pkg::bra_cmd_t cmd,
    output bra_pkg::bra_stat_t     stat,
    input  wire logic [1:0]        in_op,
    input  wire logic [31:0]       in_size,
    input  wire logic [31:0]       in_addr,
    input  wire logic [31:0]       heap_limit,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [31:0]            out_block_address,
    output logic [1:0]             out_status
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [31:0] HDR     = 32'(HEADER_BYTES);
    localparam logic [31:0] RESERVE = 32'(4 * TABLE_ENTRIES);
    localparam logic [CW-1:0] N_CW  = CW'(TABLE_ENTRIES);

    logic [31:0]          bump_reg;
    logic [31:0]          fsc_reg;
    logic [CW-1:0]        used_reg;
    logic                 ready_reg;
    logic                 halted_reg;
    bra_pkg::op_t         op_reg;
    logic [31:0]          size_reg;
    logic [31:0]          addr_reg;
    bra_pkg::scan_mode_t  mode_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        lim_reg;
    logic                 pend_reg;
    logic [IW-1:0]        pend_idx_reg;
    logic [31:0]          res_addr_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_addr_reg;
    logic [1:0]           out_status_reg;

    logic [31:0]             hdr_sum, size_sum, init_sum, aligned;
    logic                    hdr_fail, size_fail, init_fail;
    logic [bra_pkg::ENTRY_W-1:0] rdata, wdata;
    logic [IW-1:0]           waddr;
    logic                    we, re;
    logic                    e_free;
    logic [31:0]             e_len, e_base, e_addr;
    logic                    match;

    assign hdr_sum   = bump_reg + HDR;
    assign size_sum  = bump_reg + size_reg;
    assign init_sum  = addr_reg + RESERVE;
    assign hdr_fail  = hdr_sum >= heap_limit;
    assign size_fail = size_sum >= heap_limit;
    assign init_fail = init_sum >= heap_limit;
    assign aligned   = (bump_reg[bra_pkg::ALIGN_BITS-1:0] != '0)
        ? {bump_reg[31:bra_pkg::ALIGN_BITS] + (32 - bra_pkg::ALIGN_BITS)'(1),
           {bra_pkg::ALIGN_BITS{1'b0}}}
        : bump_reg;

    assign e_free = rdata[64];
    assign e_len  = rdata[63:32];
    assign e_base = rdata[31:0];
    assign e_addr = e_base + HDR;

    always_comb
    begin
        case (mode_reg)
            bra_pkg::SCAN_EXACT:  match = e_free && (e_len == size_reg);
            bra_pkg::SCAN_SHRINK: match = e_free && (e_len > size_reg);
            default:              match = (e_addr == addr_reg);
        endcase
    end

    // table write: header record or scan hit update
    always_comb
    begin
        we    = 1'b0;
        waddr = pend_idx_reg;
        wdata = {1'b0, e_len, e_base};
        if (cmd.take_hdr && !hdr_fail)
        begin
            we    = 1'b1;
            waddr = used_reg[IW-1:0];
            wdata = {1'b0, size_reg, bump_reg};
        end
        else if (cmd.hit_write)
        begin
            we = 1'b1;
            case (mode_reg)
                bra_pkg::SCAN_EXACT:  wdata = {1'b0, e_len, e_base};
                bra_pkg::SCAN_SHRINK: wdata = {1'b0, size_reg, e_base};
                default:              wdata = {1'b1, e_len, e_base};
            endcase
        end
    end

    assign re = cmd.scan_run && (idx_reg < lim_reg);

    bra_ram #(
        .WIDTH (bra_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg   <= bra_pkg::op_t'(in_op);
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (cmd.scan_start)
        begin
            mode_reg <= cmd.scan_mode;
            lim_reg  <= (cmd.scan_mode == bra_pkg::SCAN_SHRINK) ? N_CW : used_reg;
        end
        if (re)
        begin
            pend_idx_reg <= idx_reg[IW-1:0];
        end
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
        // reply value
        if (cmd.res_kind == bra_pkg::RES_HALTED)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= bra_pkg::ST_OOM;
        end
        else if (cmd.res_kind == bra_pkg::RES_NOT_FOUND)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= bra_pkg::ST_NOT_FOUND;
        end
        else if (cmd.init_op)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= init_fail ? bra_pkg::ST_OOM : bra_pkg::ST_OK;
        end
        else if (cmd.take_hdr && hdr_fail)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= bra_pkg::ST_OOM;
        end
        else if (cmd.take_size)
        begin
            res_addr_reg   <= size_fail ? 32'd0 : bump_reg;
            res_status_reg <= size_fail ? bra_pkg::ST_OOM : bra_pkg::ST_OK;
        end
        else if (cmd.hit_write)
        begin
            res_addr_reg   <= (mode_reg == bra_pkg::SCAN_FREE) ? 32'd0 : e_addr;
            res_status_reg <= bra_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg      <= '0;
            fsc_reg       <= 32'(TABLE_ENTRIES);
            used_reg      <= '0;
            ready_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_op)
            begin
                bump_reg  <= init_sum;
                ready_reg <= 1'b1;
                if (init_fail)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (cmd.align_op)
            begin
                bump_reg <= aligned;
            end
            if (cmd.take_hdr)
            begin
                bump_reg <= hdr_sum;
                if (hdr_fail)
                begin
                    halted_reg <= 1'b1;
                end
                else
                begin
                    fsc_reg  <= fsc_reg - 32'd1;
                    used_reg <= used_reg + CW'(1);
                end
            end
            if (cmd.take_size)
            begin
                bump_reg <= size_sum;
                if (size_fail)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (cmd.hit_write)
            begin
                fsc_reg <= (mode_reg == bra_pkg::SCAN_FREE) ? fsc_reg + 32'd1
                                                            : fsc_reg - 32'd1;
            end
            // one table read per cycle, checked the cycle after
            if (cmd.scan_start)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                pend_reg <= re;
                if (re)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat           = '0;
        stat.halted    = halted_reg;
        stat.op        = op_reg;
        stat.fsc_zero  = (fsc_reg == 32'd0);
        stat.fsc_lt_n  = (fsc_reg < 32'(TABLE_ENTRIES));
        stat.ready     = ready_reg;
        stat.used_zero = (used_reg == '0);
        stat.used_full = (used_reg >= N_CW);
        stat.hdr_fail  = hdr_fail;
        stat.scan_hit  = pend_reg && match;
        stat.scan_miss = !pend_reg && (idx_reg >= lim_reg);
        stat.mode      = mode_reg;
        stat.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign out_block_address = out_addr_reg;
    assign out_status        = out_status_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= N_CW)
        else $error("entry count beyond table size");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == bra_pkg::ST_OOM |-> out_addr_reg == 32'd0)
        else $error("out of memory reply with nonzero address");

endmodule
`default_nettype wire
